[src/uv_sphere_tessellator_assert.svh]
// Assertion macros for the UV sphere tessellator; empty under synthesis.
`ifndef UV_SPHERE_TESSELLATOR_ASSERT_SVH
`define UV_SPHERE_TESSELLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define UVS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UVS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/uvs_pkg.sv]
// Shared types, constants and arithmetic helpers of the UV sphere tessellator.
`default_nettype none

package uvs_pkg;

    // Parameter defaults
    localparam int MAX_STACKS_DEF = 64;
    localparam int MAX_SLICES_DEF = 64;
    localparam int TRIG_BITS_DEF  = 16;
    localparam int CORDIC_LEN     = 24;

    // Field widths
    localparam int CNT_W      = 7;
    localparam int ANG_W      = 16;
    localparam int RAD_W      = 16;
    localparam int IDX_W      = 13;
    localparam int POS_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Rotator datapath: Q2.28 vectors, binary-angle residual
    localparam int CX_W      = 32;
    localparam int CZ_W      = 18;
    localparam int TRIG_W    = 16;
    localparam int TRIG_FRAC = 14;

    localparam logic signed [CX_W-1:0] CORDIC_X0 = 32'sd163008218;

    localparam logic [ANG_W-1:0] QUARTER_TURN  = 16'd16384;
    localparam logic [ANG_W-1:0] HALF_TURN     = 16'd32768;
    localparam logic [ANG_W-1:0] THREE_QUARTER = 16'd49152;

    localparam logic signed [TRIG_W-1:0] TRIG_LIM = 16'sd16384;
    localparam logic signed [POS_W:0]    POS_LIM  = 18'sd65535;

    // Register reset values and count floors
    localparam logic [RAD_W-1:0] RADIUS_RST     = 16'd256;
    localparam logic [CNT_W-1:0] STACKS_RST     = 7'd20;
    localparam logic [CNT_W-1:0] SLICES_RST     = 7'd20;
    localparam logic [ANG_W-1:0] PHI_STEP_RST   = 16'd1638;
    localparam logic [ANG_W-1:0] THETA_STEP_RST = 16'd3277;
    localparam logic [CNT_W-1:0] STACKS_MIN     = 7'd2;
    localparam logic [CNT_W-1:0] SLICES_MIN     = 7'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS     = 3'd0,
        CFG_STACKS     = 3'd1,
        CFG_SLICES     = 3'd2,
        CFG_PHI_STEP   = 3'd3,
        CFG_THETA_STEP = 3'd4
    } t_cfg_idx;

    // What a request turns into
    typedef enum logic [2:0] {
        K_VTX     = 3'd0,
        K_NORTH   = 3'd1,
        K_SOUTH   = 3'd2,
        K_OOR     = 3'd3,
        K_TRI_TOP = 3'd4,
        K_TRI_BOT = 3'd5,
        K_TRI_IN  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } t_side;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
        logic                   neg;
    } t_rot;

    typedef struct packed {
        t_side sd;
        t_rot  ph;
        t_rot  th;
    } t_cst;

    // Arctangent of 2^-i in binary-angle units
    function automatic logic signed [CZ_W-1:0] f_atan(input int unsigned i);
        logic signed [CZ_W-1:0] v;
        case (i)
            0:       v = 18'sd8192;
            1:       v = 18'sd4836;
            2:       v = 18'sd2555;
            3:       v = 18'sd1297;
            4:       v = 18'sd651;
            5:       v = 18'sd326;
            6:       v = 18'sd163;
            7:       v = 18'sd81;
            8:       v = 18'sd41;
            9:       v = 18'sd20;
            10:      v = 18'sd10;
            11:      v = 18'sd5;
            12:      v = 18'sd3;
            13:      v = 18'sd1;
            14:      v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    // Angle reduction into [-quarter, quarter) and start vector
    function automatic t_rot f_init(input logic [ANG_W-1:0] ang);
        t_rot             o;
        logic [ANG_W-1:0] a2;
        a2    = ang;
        o.neg = 1'b0;
        if (ang >= QUARTER_TURN && ang < THREE_QUARTER) begin
            a2    = ang - HALF_TURN;
            o.neg = 1'b1;
        end
        o.x = CORDIC_X0;
        o.y = '0;
        o.z = {{(CZ_W-ANG_W){a2[ANG_W-1]}}, a2};
        return o;
    endfunction

    // One rotation micro-step
    function automatic t_rot f_rot(input t_rot v, input int unsigned i);
        t_rot                   o;
        logic signed [CX_W-1:0] dx;
        logic signed [CX_W-1:0] dy;
        dx = $signed(v.y) >>> i;
        dy = $signed(v.x) >>> i;
        o  = v;
        if (!v.z[CZ_W-1]) begin
            o.x = $signed(v.x) - dx;
            o.y = $signed(v.y) + dy;
            o.z = $signed(v.z) - f_atan(i);
        end else begin
            o.x = $signed(v.x) + dx;
            o.y = $signed(v.y) - dy;
            o.z = $signed(v.z) + f_atan(i);
        end
        return o;
    endfunction

    // Round Q2.28 to Q1.14, clamp to +-1.0, apply the half-turn sign
    function automatic logic signed [TRIG_W-1:0] f_trig_round(
        input logic signed [CX_W-1:0] v,
        input logic                   neg
    );
        logic signed [CX_W:0]           s;
        logic signed [CX_W-TRIG_FRAC:0] q;
        logic signed [TRIG_W-1:0]       c;
        s = $signed({v[CX_W-1], v}) + 33'sd8192;
        q = s[CX_W:TRIG_FRAC];
        if (q > 19'sd16384) begin
            c = TRIG_LIM;
        end else if (q < -19'sd16384) begin
            c = -TRIG_LIM;
        end else begin
            c = q[TRIG_W-1:0];
        end
        return neg ? -c : c;
    endfunction

    // Saturate a rounded position into the Q8.8 output range
    function automatic logic signed [POS_W-1:0] f_sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] o;
        if (v > POS_LIM) begin
            o = POS_LIM[POS_W-1:0];
        end else if (v < -POS_LIM) begin
            o = -POS_LIM[POS_W-1:0];
        end else begin
            o = v[POS_W-1:0];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

[src/uvs_req_if.sv]
// Request channel: operation, ring or band, segment.
`default_nettype none

interface uvs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [uvs_pkg::CNT_W-1:0]   ring_or_band;
    logic [uvs_pkg::CNT_W-1:0]   segment;

    modport source (output valid, output operation, output ring_or_band, output segment,
                    input ready);
    modport sink   (input valid, input operation, input ring_or_band, input segment,
                    output ready);
endinterface

`default_nettype wire

[src/uvs_res_if.sv]
// Result channel: vertex position or triangle corners plus flags.
`default_nettype none

interface uvs_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [uvs_pkg::POS_W-1:0]   pos_x;
    logic signed [uvs_pkg::POS_W-1:0]   pos_y;
    logic signed [uvs_pkg::POS_W-1:0]   pos_z;
    logic [uvs_pkg::IDX_W-1:0]          corner_a;
    logic [uvs_pkg::IDX_W-1:0]          corner_b;
    logic [uvs_pkg::IDX_W-1:0]          corner_c;
    logic                               last_of_run;
    logic                               out_of_range;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output corner_a, output corner_b, output corner_c,
                    output last_of_run, output out_of_range, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input corner_a, input corner_b, input corner_c,
                    input last_of_run, input out_of_range, output ready);
endinterface

`default_nettype wire

[src/uv_sphere_tessellator.sv]
// UV sphere tessellator top level: decode, dual CORDIC, multiply, output register.
// Throughput: one request per cycle; an inner-band triangle request holds the output
// register for two result transfers. Stalls back up stage by stage and fill bubbles first.
// Reset: synchronous active-low; clears all stage valid bits and loads register defaults.
`default_nettype none
`include "uv_sphere_tessellator_assert.svh"

module uv_sphere_tessellator #(
    parameter int MAX_STACKS = uvs_pkg::MAX_STACKS_DEF,
    parameter int MAX_SLICES = uvs_pkg::MAX_SLICES_DEF,
    parameter int TRIG_BITS  = uvs_pkg::TRIG_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    uvs_req_if.sink                          i_req,
    uvs_res_if.source                        o_res
);

    localparam int CW     = uvs_pkg::CNT_W;
    localparam int AW     = uvs_pkg::ANG_W;
    localparam int RW     = uvs_pkg::RAD_W;
    localparam int IW     = uvs_pkg::IDX_W;
    localparam int PW     = uvs_pkg::POS_W;
    localparam int XW     = uvs_pkg::CX_W;
    localparam int TW     = uvs_pkg::TRIG_W;
    localparam int PXW    = XW + TW - 2;
    localparam int CAP    = (1 << CW) - 1;
    localparam int ST_CAP = (MAX_STACKS > CAP) ? CAP : MAX_STACKS;
    localparam int SL_CAP = (MAX_SLICES > CAP) ? CAP : MAX_SLICES;
    localparam logic [CW-1:0] ST_MAX = ST_CAP[CW-1:0];
    localparam logic [CW-1:0] SL_MAX = SL_CAP[CW-1:0];

    localparam int CORDIC_N = (TRIG_BITS > uvs_pkg::CORDIC_LEN) ?
                              uvs_pkg::CORDIC_LEN : TRIG_BITS;
    localparam int S_IN   = 0;
    localparam int S_ANG  = 1;
    localparam int S_CORD = 2;
    localparam int S_TRIG = S_CORD + CORDIC_N;
    localparam int S_M1   = S_TRIG + 1;
    localparam int S_M2   = S_M1 + 1;
    localparam int S_OUT  = S_M2 + 1;
    localparam int NS     = S_OUT + 1;

    // ------------------------------------------------------------------
    // Configuration registers (counts stored already clamped)
    // ------------------------------------------------------------------
    logic [RW-1:0] r_radius;
    logic [CW-1:0] r_st;
    logic [CW-1:0] r_sl;
    logic [AW-1:0] r_phi_step;
    logic [AW-1:0] r_theta_step;
    logic [CW-1:0] w_cfg_cnt;
    logic [CW-1:0] n_st;
    logic [CW-1:0] n_sl;

    always_comb begin
        w_cfg_cnt = i_cfg_data[CW-1:0];
        if (w_cfg_cnt < uvs_pkg::STACKS_MIN) begin
            n_st = uvs_pkg::STACKS_MIN;
        end else if (w_cfg_cnt > ST_MAX) begin
            n_st = ST_MAX;
        end else begin
            n_st = w_cfg_cnt;
        end
        if (w_cfg_cnt < uvs_pkg::SLICES_MIN) begin
            n_sl = uvs_pkg::SLICES_MIN;
        end else if (w_cfg_cnt > SL_MAX) begin
            n_sl = SL_MAX;
        end else begin
            n_sl = w_cfg_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= uvs_pkg::RADIUS_RST;
            r_st         <= uvs_pkg::STACKS_RST;
            r_sl         <= uvs_pkg::SLICES_RST;
            r_phi_step   <= uvs_pkg::PHI_STEP_RST;
            r_theta_step <= uvs_pkg::THETA_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                uvs_pkg::CFG_RADIUS:     r_radius     <= i_cfg_data[RW-1:0];
                uvs_pkg::CFG_STACKS:     r_st         <= n_st;
                uvs_pkg::CFG_SLICES:     r_sl         <= n_sl;
                uvs_pkg::CFG_PHI_STEP:   r_phi_step   <= i_cfg_data[AW-1:0];
                uvs_pkg::CFG_THETA_STEP: r_theta_step <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and per-stage advance
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_go;
    logic          w_go_out;
    logic          r_o_last;

    // A stage loads when the output drains or any stage from it on is empty
    assign w_go_out = o_res.ready && r_o_last;

    for (genvar gk = 0; gk < NS; gk++) begin : g_go
        assign w_go[gk] = w_go_out || !(&r_vld[NS-1:gk]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_go[S_IN]) begin
                r_vld[S_IN] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_go[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_req.ready = w_go[S_IN];

    // ------------------------------------------------------------------
    // Input stage: range check and request classification
    // ------------------------------------------------------------------
    uvs_pkg::t_kind w_kind;
    uvs_pkg::t_kind r1_kind;
    logic [CW-1:0]  r1_rb;
    logic [CW-1:0]  r1_sg;

    always_comb begin
        if (!i_req.operation) begin
            if (i_req.ring_or_band > r_st || i_req.segment > r_sl) begin
                w_kind = uvs_pkg::K_OOR;
            end else if (i_req.ring_or_band == '0) begin
                w_kind = uvs_pkg::K_NORTH;
            end else if (i_req.ring_or_band == r_st) begin
                w_kind = uvs_pkg::K_SOUTH;
            end else begin
                w_kind = uvs_pkg::K_VTX;
            end
        end else begin
            if (i_req.ring_or_band >= r_st || i_req.segment >= r_sl) begin
                w_kind = uvs_pkg::K_OOR;
            end else if (i_req.ring_or_band == '0) begin
                w_kind = uvs_pkg::K_TRI_TOP;
            end else if (i_req.ring_or_band == r_st - 7'd1) begin
                w_kind = uvs_pkg::K_TRI_BOT;
            end else begin
                w_kind = uvs_pkg::K_TRI_IN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go[S_IN]) begin
            r1_kind <= w_kind;
            r1_rb   <= i_req.ring_or_band;
            r1_sg   <= i_req.segment;
        end
    end

    // ------------------------------------------------------------------
    // Angle and index stage: binary angles, triangle vertex indices (mod 2^13)
    // ------------------------------------------------------------------
    logic [AW+CW-1:0]    w_ph_prod;
    logic [AW+CW-1:0]    w_th_prod;
    logic [IW-1:0]       w_rv;
    logic [CW-1:0]       w_msel;
    logic [IW+CW-1:0]    w_row_prod;
    logic [IW-1:0]       w_first;
    logic [IW-1:0]       w_base;
    logic [IW-1:0]       w_sg13;
    uvs_pkg::t_side      w_sd2;
    uvs_pkg::t_side      r2_sd;
    logic [AW-1:0]       r2_ang_ph;
    logic [AW-1:0]       r2_ang_th;

    always_comb begin
        w_ph_prod  = r1_rb * r_phi_step;
        w_th_prod  = r1_sg * r_theta_step;
        w_rv       = {{(IW-CW){1'b0}}, r_sl} + 13'd1;
        w_msel     = (r1_kind == uvs_pkg::K_TRI_BOT) ? r1_rb : r1_rb - 7'd1;
        w_row_prod = w_msel * w_rv;
        w_first    = w_row_prod[IW-1:0] + 13'd1;
        w_base     = w_first - w_rv;
        w_sg13     = {{(IW-CW){1'b0}}, r1_sg};
        w_sd2.kind = r1_kind;
        w_sd2.a    = '0;
        w_sd2.b    = '0;
        w_sd2.c    = '0;
        case (r1_kind)
            uvs_pkg::K_TRI_TOP: begin
                w_sd2.b = w_sg13 + 13'd2;
                w_sd2.c = w_sg13 + 13'd1;
            end
            uvs_pkg::K_TRI_BOT: begin
                w_sd2.a = w_first;
                w_sd2.b = w_base + w_sg13;
                w_sd2.c = w_base + w_sg13 + 13'd1;
            end
            uvs_pkg::K_TRI_IN: begin
                w_sd2.a = w_first + w_sg13;
                w_sd2.b = w_first + w_sg13 + 13'd1;
                w_sd2.c = w_first + w_sg13 + w_rv;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go[S_ANG]) begin
            r2_sd     <= w_sd2;
            r2_ang_ph <= w_ph_prod[AW-1:0];
            r2_ang_th <= w_th_prod[AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC pipeline: one micro-rotation per stage, phi and theta side by side
    // ------------------------------------------------------------------
    uvs_pkg::t_cst w_c0;
    uvs_pkg::t_cst r_cs [CORDIC_N];

    always_comb begin
        w_c0.sd = r2_sd;
        w_c0.ph = uvs_pkg::f_init(r2_ang_ph);
        w_c0.th = uvs_pkg::f_init(r2_ang_th);
    end

    for (genvar gi = 0; gi < CORDIC_N; gi++) begin : g_cordic
        uvs_pkg::t_cst w_cin;
        uvs_pkg::t_cst w_cout;

        if (gi == 0) begin : g_first
            assign w_cin = w_c0;
        end else begin : g_next
            assign w_cin = r_cs[gi-1];
        end

        always_comb begin
            w_cout    = w_cin;
            w_cout.ph = uvs_pkg::f_rot(w_cin.ph, gi);
            w_cout.th = uvs_pkg::f_rot(w_cin.th, gi);
        end

        always_ff @(posedge i_clk) begin
            if (w_go[S_CORD+gi]) begin
                r_cs[gi] <= w_cout;
            end
        end
    end

    // ------------------------------------------------------------------
    // Trig stage: round to Q1.14, clamp, undo the half-turn reduction
    // ------------------------------------------------------------------
    uvs_pkg::t_cst           w_cl;
    uvs_pkg::t_side          r_t_sd;
    logic signed [TW-1:0]    r_t_sp;
    logic signed [TW-1:0]    r_t_cp;
    logic signed [TW-1:0]    r_t_sth;
    logic signed [TW-1:0]    r_t_cth;

    assign w_cl = r_cs[CORDIC_N-1];

    always_ff @(posedge i_clk) begin
        if (w_go[S_TRIG]) begin
            r_t_sd  <= w_cl.sd;
            r_t_sp  <= uvs_pkg::f_trig_round(w_cl.ph.y, w_cl.ph.neg);
            r_t_cp  <= uvs_pkg::f_trig_round(w_cl.ph.x, w_cl.ph.neg);
            r_t_sth <= uvs_pkg::f_trig_round(w_cl.th.y, w_cl.th.neg);
            r_t_cth <= uvs_pkg::f_trig_round(w_cl.th.x, w_cl.th.neg);
        end
    end

    // ------------------------------------------------------------------
    // Multiply 1: radius*sin(phi), radius*cos(phi)
    // ------------------------------------------------------------------
    logic signed [XW:0]      w_rsp_full;
    logic signed [XW:0]      w_ry_full;
    uvs_pkg::t_side          r_m1_sd;
    logic signed [XW-1:0]    r_m1_rsp;
    logic signed [XW-1:0]    r_m1_ry;
    logic signed [TW-1:0]    r_m1_sth;
    logic signed [TW-1:0]    r_m1_cth;

    assign w_rsp_full = $signed({1'b0, r_radius}) * r_t_sp;
    assign w_ry_full  = $signed({1'b0, r_radius}) * r_t_cp;

    always_ff @(posedge i_clk) begin
        if (w_go[S_M1]) begin
            r_m1_sd  <= r_t_sd;
            r_m1_rsp <= w_rsp_full[XW-1:0];
            r_m1_ry  <= w_ry_full[XW-1:0];
            r_m1_sth <= r_t_sth;
            r_m1_cth <= r_t_cth;
        end
    end

    // ------------------------------------------------------------------
    // Multiply 2: radius*sin(phi) times cos/sin(theta)
    // ------------------------------------------------------------------
    logic signed [XW+TW-1:0] w_px_full;
    logic signed [XW+TW-1:0] w_pz_full;
    uvs_pkg::t_side          r_m2_sd;
    logic signed [PXW-1:0]   r_m2_px;
    logic signed [PXW-1:0]   r_m2_pz;
    logic signed [XW-1:0]    r_m2_ry;

    assign w_px_full = r_m1_rsp * r_m1_cth;
    assign w_pz_full = r_m1_rsp * r_m1_sth;

    always_ff @(posedge i_clk) begin
        if (w_go[S_M2]) begin
            r_m2_sd <= r_m1_sd;
            r_m2_px <= w_px_full[PXW-1:0];
            r_m2_pz <= w_pz_full[PXW-1:0];
            r_m2_ry <= r_m1_ry;
        end
    end

    // ------------------------------------------------------------------
    // Output register: round, saturate, select by request kind
    // ------------------------------------------------------------------
    logic signed [PXW-1:0]   w_xr;
    logic signed [PXW-1:0]   w_zr;
    logic signed [XW-1:0]    w_yr;
    logic signed [PW-1:0]    w_vx;
    logic signed [PW-1:0]    w_vy;
    logic signed [PW-1:0]    w_vz;
    logic signed [PW-1:0]    w_rad;
    logic signed [PW-1:0]    n_px;
    logic signed [PW-1:0]    n_py;
    logic signed [PW-1:0]    n_pz;
    logic [IW-1:0]           n_a;
    logic [IW-1:0]           n_b;
    logic [IW-1:0]           n_c;
    logic                    n_last;
    logic                    n_oor;
    logic signed [PW-1:0]    r_o_px;
    logic signed [PW-1:0]    r_o_py;
    logic signed [PW-1:0]    r_o_pz;
    logic [IW-1:0]           r_o_a;
    logic [IW-1:0]           r_o_b;
    logic [IW-1:0]           r_o_c;
    logic                    r_o_oor;

    always_comb begin
        w_xr   = r_m2_px + 46'sd134217728;
        w_zr   = r_m2_pz + 46'sd134217728;
        w_yr   = r_m2_ry + 32'sd8192;
        w_vx   = uvs_pkg::f_sat_pos($signed(w_xr[PXW-1:28]));
        w_vz   = uvs_pkg::f_sat_pos($signed(w_zr[PXW-1:28]));
        w_vy   = uvs_pkg::f_sat_pos($signed(w_yr[XW-1:14]));
        w_rad  = $signed({1'b0, r_radius});
        n_px   = '0;
        n_py   = '0;
        n_pz   = '0;
        n_a    = '0;
        n_b    = '0;
        n_c    = '0;
        n_last = 1'b1;
        n_oor  = 1'b0;
        case (r_m2_sd.kind)
            uvs_pkg::K_VTX: begin
                n_px = w_vx;
                n_py = w_vy;
                n_pz = w_vz;
            end
            uvs_pkg::K_NORTH: n_py = w_rad;
            uvs_pkg::K_SOUTH: n_py = -w_rad;
            uvs_pkg::K_OOR:   n_oor = 1'b1;
            uvs_pkg::K_TRI_TOP, uvs_pkg::K_TRI_BOT: begin
                n_a = r_m2_sd.a;
                n_b = r_m2_sd.b;
                n_c = r_m2_sd.c;
            end
            uvs_pkg::K_TRI_IN: begin
                n_a    = r_m2_sd.a;
                n_b    = r_m2_sd.b;
                n_c    = r_m2_sd.c;
                n_last = 1'b0;
            end
            default: ;
        endcase
    end

    // Inner band: after the first transfer the second triangle is (c, b, c+1)
    always_ff @(posedge i_clk) begin
        if (w_go[S_OUT]) begin
            r_o_px   <= n_px;
            r_o_py   <= n_py;
            r_o_pz   <= n_pz;
            r_o_a    <= n_a;
            r_o_b    <= n_b;
            r_o_c    <= n_c;
            r_o_last <= n_last;
            r_o_oor  <= n_oor;
        end else if (r_vld[S_OUT] && o_res.ready && !r_o_last) begin
            r_o_a    <= r_o_c;
            r_o_c    <= r_o_c + 13'd1;
            r_o_last <= 1'b1;
        end
    end

    assign o_res.valid        = r_vld[S_OUT];
    assign o_res.pos_x        = r_o_px;
    assign o_res.pos_y        = r_o_py;
    assign o_res.pos_z        = r_o_pz;
    assign o_res.corner_a     = r_o_a;
    assign o_res.corner_b     = r_o_b;
    assign o_res.corner_c     = r_o_c;
    assign o_res.last_of_run  = r_o_last;
    assign o_res.out_of_range = r_o_oor;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `UVS_ASSERT_NEXT(a_pair_second, i_clk, i_rst_n,
        o_res.valid && o_res.ready && !o_res.last_of_run,
        o_res.valid && o_res.last_of_run && o_res.corner_b == $past(o_res.corner_b),
        "first triangle of a band pair not followed by its closing triangle")
    `UVS_ASSERT_SAME(a_oor_clean, i_clk, i_rst_n,
        o_res.valid && o_res.out_of_range,
        o_res.last_of_run && o_res.corner_a == '0 && o_res.corner_c == '0 &&
        o_res.pos_x == '0 && o_res.pos_y == '0 && o_res.pos_z == '0,
        "out-of-range result carries nonzero fields")
    `UVS_ASSERT_SAME(a_bubble_ready, i_clk, i_rst_n,
        !(&r_vld),
        i_req.ready,
        "request stalled while the pipeline has an empty stage")

endmodule

`default_nettype wire
